[rtl/core/stbs_pkg.sv]
package stbs_pkg;

   localparam int unsigned TSIZE_W   = 11;
   localparam int unsigned KEY_W     = 32;
   localparam int unsigned MATCH_W   = 10;
   localparam int unsigned PROBE_W   = 4;
   localparam int unsigned ENTRY_W   = 10;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   // register index, taken from paddr[2]
   localparam logic CSR_TABLE_SIZE = 1'b0;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   typedef struct packed {
      logic mem_write;   // store the request's entry, acknowledge
      logic load;        // capture key, open the window
      logic probe;       // read entry at midpoint
      logic check;       // compare read data, narrow window or finish
      logic finish_miss; // window empty, report not found
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic hit;
   } status_type;

endpackage

[rtl/core/stbs_ctrl.sv]
module stbs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_mode,
   input  stbs_pkg::status_type status,
   output stbs_pkg::cmd_type    cmd,
   output logic                 busy
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PROBE = 3'b010,
      ST_CHECK = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      cmd             = '0;
      state_in        = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == stbs_pkg::MODE_WRITE) begin
                  cmd.mem_write = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (status.empty) begin
               cmd.finish_miss = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd.probe = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.hit ? ST_IDLE : ST_PROBE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/stbs_datapath.sv]
module stbs_datapath #(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  stbs_pkg::cmd_type                     cmd,
   output stbs_pkg::status_type                  status,
   input  logic [stbs_pkg::TSIZE_W-1:0]          table_size,
   input  logic [stbs_pkg::ENTRY_W-1:0]          req_entry_index,
   input  logic signed [stbs_pkg::KEY_W-1:0]     req_entry_value,
   input  logic signed [stbs_pkg::KEY_W-1:0]     req_search_key,
   output logic                                  rsp_valid,
   output logic                                  rsp_found,
   output logic [stbs_pkg::MATCH_W-1:0]          rsp_match_index,
   output logic [stbs_pkg::PROBE_W-1:0]          rsp_probe_count
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned WIN_W = IDX_W + 1;
   localparam int unsigned CMP_W = (WIN_W > stbs_pkg::TSIZE_W) ? WIN_W : stbs_pkg::TSIZE_W;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

   logic [stbs_pkg::KEY_W-1:0] table_mem [TABLE_DEPTH];

   logic [WIN_W-1:0]                 lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0]                 mid_ff;
   logic [IDX_W-1:0]                 mid;
   logic [WIN_W:0]                   mid_sum;
   logic signed [stbs_pkg::KEY_W-1:0] key_ff;
   logic signed [stbs_pkg::KEY_W-1:0] rd_data_ff;
   logic [stbs_pkg::PROBE_W-1:0]     probes_ff, probes_in;
   logic [CMP_W-1:0]                 size_ext, size_sat;
   logic                             entry_in_range;
   logic                             hit, less;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic [stbs_pkg::MATCH_W-1:0]     rsp_match_ff, rsp_match_in;
   logic [stbs_pkg::PROBE_W-1:0]     rsp_probe_ff, rsp_probe_in;

   assign size_ext       = CMP_W'(table_size);
   assign size_sat       = (size_ext > DEPTH_C) ? DEPTH_C : size_ext;
   assign entry_in_range = CMP_W'(req_entry_index) < DEPTH_C;

   // floor((lo + hi - 1) / 2), only used while lo < hi
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - (WIN_W+1)'(1);
   assign mid     = mid_sum[IDX_W:1];

   assign hit  = (rd_data_ff == key_ff);
   assign less = (rd_data_ff < key_ff);

   assign status.empty = (lo_ff >= hi_ff);
   assign status.hit   = hit;

   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      probes_in = probes_ff;
      if (cmd.load) begin
         lo_in     = '0;
         hi_in     = WIN_W'(size_sat);
         probes_in = '0;
      end
      if (cmd.probe) begin
         probes_in = probes_ff + stbs_pkg::PROBE_W'(1);
      end
      if (cmd.check && !hit) begin
         if (less) begin
            lo_in = {1'b0, mid_ff} + WIN_W'(1);
         end else begin
            hi_in = {1'b0, mid_ff};
         end
      end
   end

   always_comb begin
      rsp_valid_in = cmd.mem_write || cmd.finish_miss || (cmd.check && hit);
      rsp_found_in = cmd.check && hit;
      rsp_match_in = (cmd.check && hit) ? stbs_pkg::MATCH_W'(mid_ff) : '0;
      rsp_probe_in = cmd.mem_write ? '0 : probes_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write && entry_in_range) begin
         table_mem[IDX_W'(req_entry_index)] <= req_entry_value;
      end
      if (cmd.probe) begin
         rd_data_ff <= table_mem[mid];
         mid_ff     <= mid;
      end
      if (cmd.load) begin
         key_ff <= req_search_key;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      probes_ff    <= probes_in;
      rsp_found_ff <= rsp_found_in;
      rsp_match_ff <= rsp_match_in;
      rsp_probe_ff <= rsp_probe_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_match_ff;
   assign rsp_probe_count = rsp_probe_ff;

endmodule

[rtl/core/sorted_table_binary_search_core.sv]
// Binary search over a sorted table of signed 32-bit entries. A request is
// taken when start is high and busy is low; req_mode 0 writes req_entry_value
// at req_entry_index (ignored past the table, still acknowledged), req_mode 1
// searches the first table_size entries for req_search_key. Every request
// gives one result beat, shown for exactly one cycle with rsp_valid high; the
// receiver cannot stall it. A write is acknowledged the cycle after it is
// taken and the next request may follow right away. A search making P probes
// returns its result beat after the compare of its last probe if it finds the
// key, else after a further probe state finds the window empty (P is at most
// log2(TABLE_DEPTH)+1); each probe is a registered read of the single table
// port followed by a compare, and busy stays high until the result is
// registered. table_size (byte address 0) must be written only while idle; the
// block does not enforce it. Values above TABLE_DEPTH act as TABLE_DEPTH.
module sorted_table_binary_search_core #(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_mode,
   input  logic [stbs_pkg::ENTRY_W-1:0]            req_entry_index,
   input  logic signed [stbs_pkg::KEY_W-1:0]       req_entry_value,
   input  logic signed [stbs_pkg::KEY_W-1:0]       req_search_key,
   output logic                                    rsp_valid,
   output logic                                    rsp_found,
   output logic [stbs_pkg::MATCH_W-1:0]            rsp_match_index,
   output logic [stbs_pkg::PROBE_W-1:0]            rsp_probe_count,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [stbs_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [stbs_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [stbs_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready
);

   logic [stbs_pkg::TSIZE_W-1:0] table_size_ff;
   logic [stbs_pkg::TSIZE_W-1:0] table_size_in;
   logic                         csr_write;
   stbs_pkg::cmd_type            cmd;
   stbs_pkg::status_type         status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[2] == stbs_pkg::CSR_TABLE_SIZE);

   assign table_size_in = csr_write ? pwdata[stbs_pkg::TSIZE_W-1:0] : table_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= '0;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   assign prdata = (paddr[2] == stbs_pkg::CSR_TABLE_SIZE)
                   ? stbs_pkg::CSR_DATA_W'(table_size_ff) : '0;

   stbs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   stbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .table_size      (table_size_ff),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_match_index (rsp_match_index),
      .rsp_probe_count (rsp_probe_count)
   );

   // a write is acknowledged on the next beat with a zero payload
   a_write_ack: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode == stbs_pkg::MODE_WRITE)
      |=> rsp_valid && !rsp_found && (rsp_probe_count == '0))
      else $error("write not acknowledged");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode == stbs_pkg::MODE_SEARCH) |=> busy && !rsp_valid)
      else $error("search did not hold busy");

   a_hit_probed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_probe_count != '0)
      else $error("hit reported without a probe");

   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_index == '0)
      else $error("miss with nonzero index");

endmodule
